>>> sv/cst_pkg.sv
// Package: command codes, FSM states and shared constants for the semaphore table.
package cst_pkg;

    localparam int unsigned CMD_W    = 3;
    localparam int unsigned ID_W     = 6;
    localparam int unsigned PID_W    = 8;
    localparam int unsigned COUNT_W  = 16;
    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    localparam logic [CMD_W-1:0] CMD_CREATE    = 3'd0;
    localparam logic [CMD_W-1:0] CMD_OPEN      = 3'd1;
    localparam logic [CMD_W-1:0] CMD_DESTROY   = 3'd2;
    localparam logic [CMD_W-1:0] CMD_WAIT      = 3'd3;
    localparam logic [CMD_W-1:0] CMD_POST      = 3'd4;
    localparam logic [CMD_W-1:0] CMD_MARK_TERM = 3'd5;
    localparam logic [CMD_W-1:0] CMD_MARK_LIVE = 3'd6;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_SCAN,
        ST_WAKE,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic       status;
        logic       caller_blocked;
        logic       woken_valid;
        logic [PID_W-1:0] woken_pid;
    } result_t;

endpackage

>>> sv/cst_if.sv
// Interfaces: command and result channels with valid/ready handshake.
interface cst_cmd_if
    import cst_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [CMD_W-1:0] cmd;
    logic [ID_W-1:0]  sem_id;
    logic [PID_W-1:0] pid;
    logic [COUNT_W-1:0] initial_value;

    modport source (output valid, cmd, sem_id, pid, initial_value, input ready);
    modport sink   (input valid, cmd, sem_id, pid, initial_value, output ready);
endinterface

interface cst_rsp_if
    import cst_pkg::*;
();
    logic             valid;
    logic             ready;
    logic             status;
    logic             caller_blocked;
    logic             woken_valid;
    logic [PID_W-1:0] woken_pid;

    modport source (output valid, status, caller_blocked, woken_valid, woken_pid, input ready);
    modport sink   (input valid, status, caller_blocked, woken_valid, woken_pid, output ready);
endinterface

>>> sv/cst_waiter_mem.sv
// Waiter store: one synchronous RAM holding every queue's ring of process ids.
module cst_waiter_mem
    import cst_pkg::*;
#(
    parameter int unsigned ADDR_W = 9
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [PID_W-1:0]  wr_data,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [PID_W-1:0]  rd_data
);

    logic [PID_W-1:0] mem [2**ADDR_W];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

>>> sv/counting_semaphore_table.sv
// Top level: table of counting semaphores with FIFO wait queues.
// Each command is a beat on cmd_ch and yields exactly one beat on rsp_ch.
// Wait, create, open, destroy and marking pass the read and output states;
// post adds the wake state and, with waiters queued, a scan state that purges
// terminated waiters via the one-read, one-write RAM. The next command is
// taken once the result register is free. Semaphore entries and terminated
// flags sit in flip-flops cleared by reset; the waiter RAM needs no clearing.
module counting_semaphore_table
    import cst_pkg::*;
#(
    parameter int unsigned SEM_COUNT   = 32,
    parameter int unsigned MAX_WAITERS = 16,
    parameter int unsigned MAX_PROCS   = 256
) (
    input  logic     clk,
    input  logic     rst_n,
    cst_cmd_if.sink  cmd_ch,
    cst_rsp_if.source rsp_ch
);

    localparam int unsigned SEM_W  = (SEM_COUNT > 1) ? $clog2(SEM_COUNT) : 1;
    localparam int unsigned POS_W  = (MAX_WAITERS > 1) ? $clog2(MAX_WAITERS) : 1;
    localparam int unsigned FILL_W = $clog2(MAX_WAITERS + 1);
    localparam int unsigned ADDR_W = SEM_W + POS_W;

    state_t state_reg, state_next;

    logic [SEM_COUNT-1:0]   active_reg;
    logic [COUNT_W-1:0]     count_reg [SEM_COUNT];
    logic [POS_W-1:0]       head_reg  [SEM_COUNT];
    logic [FILL_W-1:0]      fill_reg  [SEM_COUNT];
    logic [MAX_PROCS-1:0]   term_reg;

    logic [CMD_W-1:0]   cmd_reg;
    logic [SEM_W-1:0]   sem_reg;
    logic [PID_W-1:0]   pid_reg;
    logic [COUNT_W-1:0] init_reg;
    logic               id_ok_reg;
    logic [FILL_W-1:0]  scan_reg;
    logic [FILL_W-1:0]  kept_reg;
    logic               rd_live_reg;
    logic [PID_W-1:0]   first_reg;

    result_t res_reg;
    logic    res_valid_reg;

    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [PID_W-1:0]  wr_data;
    logic [ADDR_W-1:0] rd_addr;
    logic [PID_W-1:0]  rd_data;

    logic [POS_W-1:0]  head_c;
    logic [FILL_W-1:0] fill_c;
    logic              pid_ok;
    logic              rd_gone;

    function automatic logic [POS_W-1:0] wrap(input logic [POS_W-1:0] h,
                                              input logic [FILL_W-1:0] o);
        logic [FILL_W:0] s;
        begin
            s = {{(FILL_W+1-POS_W){1'b0}}, h} + {1'b0, o};
            if (s >= (FILL_W+1)'(MAX_WAITERS))
            begin
                s = s - (FILL_W+1)'(MAX_WAITERS);
            end
            wrap = s[POS_W-1:0];
        end
    endfunction

    cst_waiter_mem #(.ADDR_W(ADDR_W)) u_mem (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign head_c  = head_reg[sem_reg];
    assign fill_c  = fill_reg[sem_reg];
    assign pid_ok  = ({1'b0, pid_reg} < (PID_W+1)'(MAX_PROCS));
    assign rd_gone = ({1'b0, rd_data} >= (PID_W+1)'(MAX_PROCS))
                     || term_reg[rd_data[$clog2(MAX_PROCS)-1:0]];

    assign cmd_ch.ready         = (state_reg == ST_IDLE) && !res_valid_reg;
    assign rsp_ch.valid         = res_valid_reg;
    assign rsp_ch.status        = res_reg.status;
    assign rsp_ch.caller_blocked = res_reg.caller_blocked;
    assign rsp_ch.woken_valid   = res_reg.woken_valid;
    assign rsp_ch.woken_pid     = res_reg.woken_pid;

    always_comb
    begin
        state_next = state_reg;
        wr_en   = 1'b0;
        wr_addr = {sem_reg, wrap(head_c, fill_c)};
        wr_data = pid_reg;
        rd_addr = {sem_reg, wrap(head_c, scan_reg)};
        case (state_reg)
            ST_IDLE:
            begin
                if (cmd_ch.valid && cmd_ch.ready)
                begin
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                if (id_ok_reg && cmd_reg == CMD_POST && active_reg[sem_reg])
                begin
                    state_next = (fill_c == '0) ? ST_WAKE : ST_SCAN;
                end
                else
                begin
                    state_next = ST_OUT;
                end
                if (id_ok_reg && cmd_reg == CMD_WAIT && active_reg[sem_reg] && pid_ok
                    && count_reg[sem_reg] == '0 && fill_c < FILL_W'(MAX_WAITERS))
                begin
                    wr_en = 1'b1;
                end
            end
            ST_SCAN:
            begin
                if (rd_live_reg && !rd_gone)
                begin
                    wr_en   = 1'b1;
                    wr_addr = {sem_reg, wrap(head_c, kept_reg)};
                    wr_data = rd_data;
                end
                if (scan_reg == fill_c)
                begin
                    state_next = ST_WAKE;
                end
            end
            ST_WAKE:
            begin
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            res_valid_reg <= 1'b0;
            active_reg    <= '0;
            term_reg      <= '0;
            rd_live_reg   <= 1'b0;
            for (int i = 0; i < SEM_COUNT; i++)
            begin
                count_reg[i] <= '0;
                head_reg[i]  <= '0;
                fill_reg[i]  <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            if (res_valid_reg && rsp_ch.ready)
            begin
                res_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (cmd_ch.valid && cmd_ch.ready)
                    begin
                        cmd_reg     <= cmd_ch.cmd;
                        sem_reg     <= cmd_ch.sem_id[SEM_W-1:0];
                        id_ok_reg   <= ({1'b0, cmd_ch.sem_id} < (ID_W+1)'(SEM_COUNT));
                        pid_reg     <= cmd_ch.pid;
                        init_reg    <= cmd_ch.initial_value;
                        res_reg     <= '{status: 1'b1, caller_blocked: 1'b0,
                                         woken_valid: 1'b0, woken_pid: '0};
                        scan_reg    <= '0;
                        kept_reg    <= '0;
                        rd_live_reg <= 1'b0;
                    end
                end
                ST_READ:
                begin
                    if (cmd_reg == CMD_MARK_TERM || cmd_reg == CMD_MARK_LIVE)
                    begin
                        if (pid_ok)
                        begin
                            term_reg[pid_reg[$clog2(MAX_PROCS)-1:0]] <= (cmd_reg == CMD_MARK_TERM);
                            res_reg.status <= 1'b0;
                        end
                    end
                    else if (id_ok_reg)
                    begin
                        case (cmd_reg)
                            CMD_CREATE:
                            begin
                                if (!active_reg[sem_reg])
                                begin
                                    active_reg[sem_reg] <= 1'b1;
                                    count_reg[sem_reg]  <= init_reg;
                                    head_reg[sem_reg]   <= '0;
                                    fill_reg[sem_reg]   <= '0;
                                    res_reg.status      <= 1'b0;
                                end
                            end
                            CMD_OPEN:
                            begin
                                res_reg.status <= !active_reg[sem_reg];
                            end
                            CMD_DESTROY:
                            begin
                                if (active_reg[sem_reg])
                                begin
                                    active_reg[sem_reg] <= 1'b0;
                                    count_reg[sem_reg]  <= '0;
                                    head_reg[sem_reg]   <= '0;
                                    fill_reg[sem_reg]   <= '0;
                                    res_reg.status      <= 1'b0;
                                end
                            end
                            CMD_WAIT:
                            begin
                                if (active_reg[sem_reg] && pid_ok)
                                begin
                                    if (count_reg[sem_reg] != '0)
                                    begin
                                        count_reg[sem_reg] <= count_reg[sem_reg] - 1'b1;
                                        res_reg.status     <= 1'b0;
                                    end
                                    else if (fill_c < FILL_W'(MAX_WAITERS))
                                    begin
                                        fill_reg[sem_reg]      <= fill_c + 1'b1;
                                        res_reg.status         <= 1'b0;
                                        res_reg.caller_blocked <= 1'b1;
                                    end
                                end
                            end
                            CMD_POST:
                            begin
                                if (active_reg[sem_reg])
                                begin
                                    res_reg.status <= 1'b0;
                                    scan_reg       <= FILL_W'(1);
                                    rd_live_reg    <= 1'b1;
                                end
                            end
                            default:
                            begin
                            end
                        endcase
                    end
                end
                ST_SCAN:
                begin
                    if (rd_live_reg && !rd_gone)
                    begin
                        kept_reg <= kept_reg + 1'b1;
                        if (kept_reg == '0)
                        begin
                            first_reg <= rd_data;
                        end
                    end
                    if (scan_reg == fill_c)
                    begin
                        fill_reg[sem_reg] <= kept_reg + FILL_W'(rd_live_reg && !rd_gone);
                        rd_live_reg       <= 1'b0;
                    end
                    else
                    begin
                        scan_reg <= scan_reg + 1'b1;
                    end
                end
                ST_WAKE:
                begin
                    if (fill_c != '0)
                    begin
                        res_reg.woken_valid <= 1'b1;
                        res_reg.woken_pid   <= first_reg;
                        head_reg[sem_reg]   <= wrap(head_c, FILL_W'(1));
                        fill_reg[sem_reg]   <= fill_c - 1'b1;
                    end
                    else if (count_reg[sem_reg] != COUNT_MAX)
                    begin
                        count_reg[sem_reg] <= count_reg[sem_reg] + 1'b1;
                    end
                end
                ST_OUT:
                begin
                    res_valid_reg <= 1'b1;
                end
                default:
                begin
                end
            endcase
        end
    end

endmodule

>>> verif/tb_counting_semaphore_table.sv
// Testbench: directed table plus random command streams, checked against a local semaphore predictor.
module tb_counting_semaphore_table;
    import cst_pkg::*;

    localparam int NSEM  = 32;
    localparam int NWAIT = 16;
    localparam int NPROC = 256;
    localparam int N_RANDOM = 1930;

    typedef struct {
        logic [CMD_W-1:0]   cmd;
        logic [ID_W-1:0]    sem_id;
        logic [PID_W-1:0]   pid;
        logic [COUNT_W-1:0] initial_value;
        bit                 fixed;
        result_t            want;
    } cmd_row_t;

    logic clk = 0;
    logic rst_n = 0;
    always #6 clk = ~clk;

    cst_cmd_if cmd_ch();
    cst_rsp_if rsp_ch();

    counting_semaphore_table dut (
        .clk(clk), .rst_n(rst_n), .cmd_ch(cmd_ch), .rsp_ch(rsp_ch)
    );

    bit                 p_active [NSEM];
    logic [COUNT_W-1:0] p_count  [NSEM];
    logic [PID_W-1:0]   p_store  [NSEM][NWAIT];
    int                 p_head   [NSEM];
    int                 p_fill   [NSEM];
    bit                 p_term   [NPROC];

    result_t pending_rsp[$];
    cmd_row_t stim[$];
    int errors = 0;
    int n_rsp = 0;
    int n_woken = 0;
    int n_blocked = 0;
    bit stall_long = 0;
    bit stim_done = 0;

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] exp);
        $display("mismatch at response %0d: %s got %0h expected %0h", n_rsp, what, got, exp);
        errors++;
    endtask

    function automatic result_t predict_semaphore(input cmd_row_t r);
        result_t res;
        int s;
        int kept;
        logic [PID_W-1:0] q;
        res = '0;
        res.status = 1'b1;
        s = r.sem_id;
        if (r.cmd == CMD_MARK_TERM || r.cmd == CMD_MARK_LIVE) begin
            p_term[r.pid] = (r.cmd == CMD_MARK_TERM);
            res.status = 1'b0;
        end
        else if (s < NSEM) begin
            case (r.cmd)
                CMD_CREATE:
                    if (!p_active[s])
                    begin
                        p_active[s] = 1; p_count[s] = r.initial_value;
                        p_head[s] = 0; p_fill[s] = 0; res.status = 0;
                    end
                CMD_OPEN: if (p_active[s]) res.status = 0;
                CMD_DESTROY:
                    if (p_active[s])
                    begin
                        p_active[s] = 0; p_count[s] = 0;
                        p_head[s] = 0; p_fill[s] = 0; res.status = 0;
                    end
                CMD_WAIT:
                    if (p_active[s])
                    begin
                        if (p_count[s] > 0)
                        begin
                            p_count[s]--; res.status = 0;
                        end
                        else if (p_fill[s] < NWAIT)
                        begin
                            p_store[s][(p_head[s] + p_fill[s]) % NWAIT] = r.pid;
                            p_fill[s]++; res.caller_blocked = 1; res.status = 0;
                        end
                    end
                CMD_POST:
                    if (p_active[s])
                    begin
                        kept = 0;
                        for (int i = 0; i < p_fill[s]; i++)
                        begin
                            q = p_store[s][(p_head[s] + i) % NWAIT];
                            if (!p_term[q])
                            begin
                                p_store[s][(p_head[s] + kept) % NWAIT] = q;
                                kept++;
                            end
                        end
                        p_fill[s] = kept;
                        if (kept > 0)
                        begin
                            res.woken_valid = 1;
                            res.woken_pid = p_store[s][p_head[s]];
                            p_head[s] = (p_head[s] + 1) % NWAIT;
                            p_fill[s]--;
                        end
                        else if (p_count[s] != COUNT_MAX)
                            p_count[s]++;
                        res.status = 0;
                    end
                default: ;
            endcase
        end
        return res;
    endfunction

    function automatic cmd_row_t mk(input logic [CMD_W-1:0] c, input int s, input int p,
                                    input int v, input bit fx = 0, input result_t w = '0);
        cmd_row_t r;
        r.cmd = c; r.sem_id = ID_W'(s); r.pid = PID_W'(p);
        r.initial_value = COUNT_W'(v); r.fixed = fx; r.want = w;
        return r;
    endfunction

    function automatic result_t rs(input bit st, input bit bl = 0, input bit wv = 0,
                                   input int wp = 0);
        result_t r;
        r.status = st; r.caller_blocked = bl; r.woken_valid = wv; r.woken_pid = PID_W'(wp);
        return r;
    endfunction

    initial
    begin
        cmd_row_t r;
        int k, s;
        stim.push_back(mk(CMD_OPEN, 0, 0, 0, 1, rs(1)));
        stim.push_back(mk(CMD_WAIT, 3, 1, 0, 1, rs(1)));
        stim.push_back(mk(CMD_POST, 3, 0, 0, 1, rs(1)));
        stim.push_back(mk(CMD_DESTROY, 3, 0, 0, 1, rs(1)));
        stim.push_back(mk(CMD_CREATE, 63, 0, 0, 1, rs(1)));
        stim.push_back(mk(3'd7, 0, 0, 0, 1, rs(1)));
        stim.push_back(mk(CMD_CREATE, 31, 0, 16'hFFFF, 1, rs(0)));
        stim.push_back(mk(CMD_CREATE, 31, 0, 0, 1, rs(1)));
        stim.push_back(mk(CMD_POST, 31, 0, 0, 1, rs(0)));
        stim.push_back(mk(CMD_WAIT, 31, 255, 0, 1, rs(0)));
        stim.push_back(mk(CMD_CREATE, 0, 0, 0, 1, rs(0)));
        stim.push_back(mk(CMD_WAIT, 0, 10, 0, 1, rs(0, 1)));
        stim.push_back(mk(CMD_WAIT, 0, 11, 0, 1, rs(0, 1)));
        stim.push_back(mk(CMD_WAIT, 0, 12, 0));
        stim.push_back(mk(CMD_MARK_TERM, 40, 10, 0, 1, rs(0)));
        stim.push_back(mk(CMD_MARK_TERM, 0, 11, 0));
        stim.push_back(mk(CMD_MARK_LIVE, 0, 11, 0));
        stim.push_back(mk(CMD_POST, 0, 0, 0, 1, rs(0, 0, 1, 11)));
        stim.push_back(mk(CMD_POST, 0, 0, 0));
        stim.push_back(mk(CMD_POST, 0, 0, 0));
        for (k = 0; k < 17; k++)
            stim.push_back(mk(CMD_WAIT, 0, 100 + k, 0));
        stim.push_back(mk(CMD_MARK_LIVE, 0, 10, 0));
        stim.push_back(mk(CMD_DESTROY, 0, 0, 0));
        stim.push_back(mk(CMD_OPEN, 0, 0, 0, 1, rs(1)));
        for (k = 0; k < N_RANDOM; k++)
        begin
            s = $urandom_range(0, 9) == 0 ? $urandom_range(0, 63) : $urandom_range(0, 3);
            case ($urandom_range(0, 19))
                0: r = mk(CMD_CREATE, s, $urandom, $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 2));
                1: r = mk(CMD_OPEN, s, $urandom, $urandom);
                2: r = mk($urandom_range(0, 4) == 0 ? 3'd7 : CMD_DESTROY, s, $urandom, $urandom);
                3, 4, 5, 6, 7, 8: r = mk(CMD_WAIT, s, $urandom_range(0, 1) ? $urandom_range(0, 15) : $urandom, $urandom);
                9, 10, 11, 12, 13: r = mk(CMD_POST, s, $urandom, $urandom);
                14, 15: r = mk(CMD_MARK_TERM, $urandom, $urandom_range(0, 15), $urandom);
                default: r = mk(CMD_MARK_LIVE, $urandom, $urandom_range(0, 1) ? $urandom_range(0, 15) : $urandom, $urandom);
            endcase
            if ($urandom_range(0, 60) == 0)
                r = mk(CMD_CREATE, s, $urandom, 16'hFFFF);
            stim.push_back(r);
        end
    end

    // sender
    initial
    begin
        int burst, gap, idx;
        cmd_ch.valid = 0; cmd_ch.cmd = '0; cmd_ch.sem_id = '0;
        cmd_ch.pid = '0; cmd_ch.initial_value = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);
        idx = 0;
        while (idx < stim.size())
        begin
            burst = $urandom_range(1, 30);
            while (burst > 0 && idx < stim.size())
            begin
                cmd_ch.valid <= 1;
                cmd_ch.cmd <= stim[idx].cmd; cmd_ch.sem_id <= stim[idx].sem_id;
                cmd_ch.pid <= stim[idx].pid; cmd_ch.initial_value <= stim[idx].initial_value;
                @(posedge clk);
                while (!cmd_ch.ready) @(posedge clk);
                begin
                    result_t p;
                    p = predict_semaphore(stim[idx]);
                    if (stim[idx].fixed && p != stim[idx].want)
                        report("table entry", p, stim[idx].want);
                    pending_rsp.push_back(p);
                end
                idx++; burst--;
            end
            gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 40);
            if (gap > 0)
            begin
                cmd_ch.valid <= 0;
                repeat (gap) @(posedge clk);
            end
        end
        cmd_ch.valid <= 0;
        stim_done = 1;
    end

    // long receiver hold-off
    initial
    begin
        wait (rst_n);
        repeat (300) @(posedge clk);
        stall_long = 1;
        repeat (400) @(posedge clk);
        stall_long = 0;
    end

    // receiver stall pattern
    initial
    begin
        int ph;
        rsp_ch.ready = 0;
        wait (rst_n);
        ph = 0;
        forever
        begin
            @(posedge clk);
            ph++;
            if (stall_long)
                rsp_ch.ready <= 0;
            else if ((ph / 200) % 2 == 0)
                rsp_ch.ready <= 1;
            else
                rsp_ch.ready <= ((ph % 7) < 3) || ($urandom_range(0, 3) == 0);
        end
    end

    // response checker
    always @(posedge clk)
    begin
        result_t w;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            n_rsp++;
            if (pending_rsp.size() == 0)
                report("unexpected response", 1, 0);
            else
            begin
                w = pending_rsp.pop_front();
                if (rsp_ch.status !== w.status) report("status", rsp_ch.status, w.status);
                if (rsp_ch.caller_blocked !== w.caller_blocked)
                    report("caller_blocked", rsp_ch.caller_blocked, w.caller_blocked);
                if (rsp_ch.woken_valid !== w.woken_valid)
                    report("woken_valid", rsp_ch.woken_valid, w.woken_valid);
                if (rsp_ch.woken_pid !== w.woken_pid)
                    report("woken_pid", rsp_ch.woken_pid, w.woken_pid);
                n_woken += w.woken_valid;
                n_blocked += w.caller_blocked;
            end
        end
    end

    initial
    begin
        wait (stim_done);
        while (pending_rsp.size() != 0) @(posedge clk);
        repeat (50) @(posedge clk);
        $display("ran %0d commands, %0d responses: %0d waits blocked, %0d waiters woken",
                 stim.size(), n_rsp, n_blocked, n_woken);
        if (errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    initial
    begin
        #8000000;
        $display("FAILURE");
        $finish;
    end
endmodule
